/* rtl/mlcr_pkg.sv */
// Shared constants and types for the midpoint line color rasterizer.
`default_nettype none

package mlcr_pkg;

  localparam int COORD_BITS_DEF   = 12;
  localparam int CHANNEL_BITS_DEF = 8;

  // Four color channels per pixel, red first and in the top byte.
  localparam int NUM_CHANNELS = 4;
  localparam int LAST_CHAN    = NUM_CHANNELS - 1;
  localparam int CHAN_IDX_W   = $clog2(NUM_CHANNELS);

  // Input item operation codes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Commands from the sequencer to the line walker.
  typedef struct packed {
    logic prep_diff;
    logic prep_order;
    logic advance;
  } walk_cmd_t;

endpackage

`default_nettype wire

/* rtl/mlcr_if.sv */
// Valid/ready channel interfaces for segment commands and pixel results.
`default_nettype none

interface mlcr_in_if #(
  parameter int COORD_BITS   = mlcr_pkg::COORD_BITS_DEF,
  parameter int CHANNEL_BITS = mlcr_pkg::CHANNEL_BITS_DEF
);
  logic                                             valid;
  logic                                             ready;
  logic                                             operation;
  logic signed [COORD_BITS-1:0]                     x_start;
  logic signed [COORD_BITS-1:0]                     y_start;
  logic signed [COORD_BITS-1:0]                     x_end;
  logic signed [COORD_BITS-1:0]                     y_end;
  logic [mlcr_pkg::NUM_CHANNELS*CHANNEL_BITS-1:0]   color_start;
  logic [mlcr_pkg::NUM_CHANNELS*CHANNEL_BITS-1:0]   color_end;

  modport source (
    output valid, operation, x_start, y_start, x_end, y_end, color_start, color_end,
    input  ready
  );
  modport sink (
    input  valid, operation, x_start, y_start, x_end, y_end, color_start, color_end,
    output ready
  );
endinterface

interface mlcr_out_if #(
  parameter int COORD_BITS   = mlcr_pkg::COORD_BITS_DEF,
  parameter int CHANNEL_BITS = mlcr_pkg::CHANNEL_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic [CHANNEL_BITS-1:0]      red;
  logic [CHANNEL_BITS-1:0]      green;
  logic [CHANNEL_BITS-1:0]      blue;
  logic [CHANNEL_BITS-1:0]      opacity;
  logic                         last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, red, green, blue, opacity, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, red, green, blue, opacity, last_pixel,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/midpoint_line_color_raster.sv */
// Top level of the midpoint line rasterizer with per-pixel color interpolation.
//
// The input channel takes one item at a time. A load item (operation 0) gives two
// signed endpoints and their packed RGBA colors; it emits nothing and replaces any
// segment in progress. Setup then runs through the PREP_DIFF and PREP_ORDER states.
// A step item (operation 1) emits one pixel while a segment is active and nothing
// otherwise. Pixels start at the endpoint with the smaller major coordinate, run along
// the major axis and stop one short of the other endpoint; last_pixel marks the last.
// Each channel is (c0*(len-i) + c1*i) / len, computed on one shared multiplier
// (two passes) and one shared restoring divider (one quotient bit per cycle), so a
// step item occupies the block until all four channels are divided and its pixel is emitted.
// in_ch.ready is high only while the sequencer is idle.
// Results leave through an output register: the next item is accepted while a pixel
// waits there, and a finished pixel waits inside the block until the register frees.
// Synchronous reset clears the sequencer, the active-segment flag and out_ch.valid.
`default_nettype none

module midpoint_line_color_raster #(
  parameter int COORD_BITS   = mlcr_pkg::COORD_BITS_DEF,
  parameter int CHANNEL_BITS = mlcr_pkg::CHANNEL_BITS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  mlcr_in_if.sink   in_ch,
  mlcr_out_if.source out_ch
);

  localparam int CW  = COORD_BITS;
  localparam int CB  = CHANNEL_BITS;
  localparam int NW  = COORD_BITS + CHANNEL_BITS;
  localparam int COL = mlcr_pkg::NUM_CHANNELS * CHANNEL_BITS;
  localparam int CIW = mlcr_pkg::CHAN_IDX_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP_DIFF,
    S_PREP_ORDER,
    S_MUL_LO,
    S_MUL_HI,
    S_DIV_GO,
    S_DIV_WAIT,
    S_EMIT
  } state_t;

  state_t               state_r;
  logic [CIW-1:0]       ch_r;
  logic                 out_valid_r;
  logic signed [CW-1:0] out_x_r;
  logic signed [CW-1:0] out_y_r;
  logic [CB-1:0]        out_red_r;
  logic [CB-1:0]        out_green_r;
  logic [CB-1:0]        out_blue_r;
  logic [CB-1:0]        out_opacity_r;
  logic                 out_last_r;
  logic [CB-1:0]        chan_r [mlcr_pkg::NUM_CHANNELS];

  logic signed [CW-1:0] xa_r;
  logic signed [CW-1:0] ya_r;
  logic signed [CW-1:0] xb_r;
  logic signed [CW-1:0] yb_r;
  logic [COL-1:0]       ca_r;
  logic [COL-1:0]       cb_r;
  logic [NW-1:0]        acc_r;

  logic                 in_take;
  logic                 out_free;
  mlcr_pkg::walk_cmd_t  wcmd;
  logic                 w_busy;
  logic signed [CW-1:0] w_px;
  logic signed [CW-1:0] w_py;
  logic [CW-1:0]        w_cnt;
  logic [CW-1:0]        w_span;
  logic [COL-1:0]       w_c0;
  logic [COL-1:0]       w_c1;
  logic                 w_last;

  logic [CB-1:0]        c0_chan;
  logic [CB-1:0]        c1_chan;
  logic [CB-1:0]        m_a;
  logic [CW-1:0]        m_b;
  logic [NW-1:0]        prod;
  logic                 div_start;
  logic                 div_done;
  logic [CB-1:0]        div_quo;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign wcmd.prep_diff  = (state_r == S_PREP_DIFF);
  assign wcmd.prep_order = (state_r == S_PREP_ORDER);
  assign wcmd.advance    = (state_r == S_EMIT) && out_free;

  always_ff @(posedge clk) begin
    if (in_take) begin
      xa_r <= in_ch.x_start;
      ya_r <= in_ch.y_start;
      xb_r <= in_ch.x_end;
      yb_r <= in_ch.y_end;
      ca_r <= in_ch.color_start;
      cb_r <= in_ch.color_end;
    end
  end

  mlcr_walk #(
    .COORD_BITS   (COORD_BITS),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_walk (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (wcmd),
    .x_start      (xa_r),
    .y_start      (ya_r),
    .x_end        (xb_r),
    .y_end        (yb_r),
    .color_start  (ca_r),
    .color_end    (cb_r),
    .busy         (w_busy),
    .pixel_x      (w_px),
    .pixel_y      (w_py),
    .step_count   (w_cnt),
    .span_length  (w_span),
    .first_color  (w_c0),
    .second_color (w_c1),
    .last_pixel   (w_last)
  );

  // Channel 0 is red, stored in the top bits of the packed color.
  assign c0_chan = w_c0[(mlcr_pkg::LAST_CHAN - int'(ch_r)) * CB +: CB];
  assign c1_chan = w_c1[(mlcr_pkg::LAST_CHAN - int'(ch_r)) * CB +: CB];

  // Shared multiplier: first pass c0*(len-i), second pass c1*i.
  assign m_a  = (state_r == S_MUL_LO) ? c0_chan : c1_chan;
  assign m_b  = (state_r == S_MUL_LO) ? (w_span - w_cnt) : w_cnt;
  assign prod = m_a * m_b;

  always_ff @(posedge clk) begin
    if (state_r == S_MUL_LO) begin
      acc_r <= prod;
    end else if (state_r == S_MUL_HI) begin
      acc_r <= acc_r + prod;
    end
  end

  assign div_start = (state_r == S_DIV_GO);

  mlcr_div #(
    .NUM_W (NW),
    .DEN_W (CW),
    .QUO_W (CB)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (acc_r),
    .den   (w_span),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_take) begin
            if (in_ch.operation == mlcr_pkg::OP_LOAD) begin
              state_r <= S_PREP_DIFF;
            end else if (w_busy) begin
              ch_r    <= '0;
              state_r <= S_MUL_LO;
            end
          end
        end
        S_PREP_DIFF: begin
          state_r <= S_PREP_ORDER;
        end
        S_PREP_ORDER: begin
          state_r <= S_IDLE;
        end
        S_MUL_LO: begin
          state_r <= S_MUL_HI;
        end
        S_MUL_HI: begin
          state_r <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state_r <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            chan_r[ch_r] <= div_quo;
            if (ch_r == CIW'(mlcr_pkg::LAST_CHAN)) begin
              state_r <= S_EMIT;
            end else begin
              ch_r    <= ch_r + 1'b1;
              state_r <= S_MUL_LO;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_x_r       <= w_px;
            out_y_r       <= w_py;
            out_red_r     <= chan_r[0];
            out_green_r   <= chan_r[1];
            out_blue_r    <= chan_r[2];
            out_opacity_r <= div_quo;
            out_last_r    <= w_last;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pixel_x    = out_x_r;
  assign out_ch.pixel_y    = out_y_r;
  assign out_ch.red        = out_red_r;
  assign out_ch.green      = out_green_r;
  assign out_ch.blue       = out_blue_r;
  assign out_ch.opacity    = out_opacity_r;
  assign out_ch.last_pixel = out_last_r;

endmodule

`default_nettype wire

/* rtl/mlcr_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module mlcr_div #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 12,
  parameter int QUO_W = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [QUO_W-1:0]      quo
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [DEN_W-1:0] rem_r;
  logic [QUO_W-1:0] low_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;

  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   trial;
  logic             fits;

  // The caller guarantees num < den * 2**QUO_W, so the top bits already sit below den.
  assign shifted = {rem_r, low_r[QUO_W-1]};
  assign trial   = shifted - {1'b0, den_r};
  assign fits    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && run_r && (cnt_r == CNT_W'(1));
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(QUO_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  // Remaining dividend bits shift out of the top of low_r while quotient bits enter below.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[NUM_W-1:QUO_W];
      low_r <= num[QUO_W-1:0];
      den_r <= den;
    end else if (run_r) begin
      rem_r <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
      low_r <= {low_r[QUO_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = low_r;

endmodule

`default_nettype wire

/* rtl/mlcr_walk.sv */
// Segment setup and midpoint line stepping state.
`default_nettype none

module mlcr_walk #(
  parameter int COORD_BITS   = mlcr_pkg::COORD_BITS_DEF,
  parameter int CHANNEL_BITS = mlcr_pkg::CHANNEL_BITS_DEF
) (
  input  wire logic                                           clk,
  input  wire logic                                           rst_n,
  input  wire mlcr_pkg::walk_cmd_t                            cmd,
  input  wire logic signed [COORD_BITS-1:0]                   x_start,
  input  wire logic signed [COORD_BITS-1:0]                   y_start,
  input  wire logic signed [COORD_BITS-1:0]                   x_end,
  input  wire logic signed [COORD_BITS-1:0]                   y_end,
  input  wire logic [mlcr_pkg::NUM_CHANNELS*CHANNEL_BITS-1:0] color_start,
  input  wire logic [mlcr_pkg::NUM_CHANNELS*CHANNEL_BITS-1:0] color_end,
  output logic                                                busy,
  output logic signed [COORD_BITS-1:0]                        pixel_x,
  output logic signed [COORD_BITS-1:0]                        pixel_y,
  output logic [COORD_BITS-1:0]                               step_count,
  output logic [COORD_BITS-1:0]                               span_length,
  output logic [mlcr_pkg::NUM_CHANNELS*CHANNEL_BITS-1:0]      first_color,
  output logic [mlcr_pkg::NUM_CHANNELS*CHANNEL_BITS-1:0]      second_color,
  output logic                                                last_pixel
);

  localparam int CW  = COORD_BITS;
  localparam int DW  = COORD_BITS + 4;
  localparam int COL = mlcr_pkg::NUM_CHANNELS * CHANNEL_BITS;

  logic signed [CW:0]   dx_r;
  logic signed [CW:0]   dy_r;
  logic                 busy_r;
  logic signed [CW-1:0] major_r;
  logic signed [CW-1:0] minor_r;
  logic signed [DW-1:0] dec_r;
  logic signed [DW-1:0] inc_up_r;
  logic signed [DW-1:0] inc_dn_r;
  logic                 steep_r;
  logic                 down_r;
  logic [CW-1:0]        cnt_r;
  logic [CW-1:0]        span_r;
  logic [COL-1:0]       c0_r;
  logic [COL-1:0]       c1_r;

  logic signed [CW:0]   adx_full;
  logic signed [CW:0]   ady_full;
  logic [CW-1:0]        adx;
  logic [CW-1:0]        ady;
  logic                 steep;
  logic                 swap;
  logic                 minor_neg;
  logic                 minor_zero;
  logic [CW-1:0]        span;
  logic [CW-1:0]        mspan;
  logic signed [DW-1:0] two_min;
  logic signed [DW-1:0] two_span;
  logic signed [DW-1:0] span_ext;
  logic [CW-1:0]        cnt_nxt;

  assign adx_full = dx_r[CW] ? -dx_r : dx_r;
  assign ady_full = dy_r[CW] ? -dy_r : dy_r;
  assign adx      = adx_full[CW-1:0];
  assign ady      = ady_full[CW-1:0];

  // Equal magnitudes keep x as the major axis.
  assign steep      = ady > adx;
  assign swap       = steep ? dy_r[CW] : dx_r[CW];
  assign minor_neg  = steep ? dx_r[CW] : dy_r[CW];
  assign span       = steep ? ady : adx;
  assign mspan      = steep ? adx : ady;
  assign minor_zero = (mspan == '0);

  assign two_min  = $signed({{(DW-CW-1){1'b0}}, mspan, 1'b0});
  assign two_span = $signed({{(DW-CW-1){1'b0}}, span, 1'b0});
  assign span_ext = $signed({{(DW-CW){1'b0}}, span});

  assign cnt_nxt  = cnt_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (cmd.prep_order) begin
      busy_r <= (span != '0);
    end else if (cmd.advance && busy_r) begin
      busy_r <= (cnt_nxt != span_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep_diff) begin
      dx_r <= {x_end[CW-1], x_end} - {x_start[CW-1], x_start};
      dy_r <= {y_end[CW-1], y_end} - {y_start[CW-1], y_start};
    end
    if (cmd.prep_order) begin
      steep_r  <= steep;
      // After ordering by the major axis the minor direction flips when the ends swapped.
      down_r   <= (minor_neg ^ swap) && !minor_zero;
      major_r  <= swap ? (steep ? y_end : x_end) : (steep ? y_start : x_start);
      minor_r  <= swap ? (steep ? x_end : y_end) : (steep ? x_start : y_start);
      span_r   <= span;
      dec_r    <= two_min - span_ext;
      inc_up_r <= two_min;
      inc_dn_r <= two_min - two_span;
      cnt_r    <= '0;
      c0_r     <= swap ? color_end : color_start;
      c1_r     <= swap ? color_start : color_end;
    end else if (cmd.advance && busy_r) begin
      if (dec_r[DW-1] || dec_r == '0) begin
        dec_r <= dec_r + inc_up_r;
      end else begin
        dec_r   <= dec_r + inc_dn_r;
        minor_r <= down_r ? minor_r - 1'b1 : minor_r + 1'b1;
      end
      major_r <= major_r + 1'b1;
      cnt_r   <= cnt_nxt;
    end
  end

  assign busy         = busy_r;
  assign pixel_x      = steep_r ? minor_r : major_r;
  assign pixel_y      = steep_r ? major_r : minor_r;
  assign step_count   = cnt_r;
  assign span_length  = span_r;
  assign first_color  = c0_r;
  assign second_color = c1_r;
  assign last_pixel   = (cnt_nxt == span_r);

endmodule

`default_nettype wire

/* rtl/mlcr_checker.sv */
// Port-level checks for the line rasterizer and their binding to the top level.
`default_nettype none

module mlcr_checker #(
  parameter int COORD_BITS   = mlcr_pkg::COORD_BITS_DEF,
  parameter int CHANNEL_BITS = mlcr_pkg::CHANNEL_BITS_DEF
) (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         in_operation,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic signed [COORD_BITS-1:0] out_pixel_x,
  input wire logic signed [COORD_BITS-1:0] out_pixel_y,
  input wire logic [CHANNEL_BITS-1:0]      out_red,
  input wire logic [CHANNEL_BITS-1:0]      out_green,
  input wire logic [CHANNEL_BITS-1:0]      out_blue,
  input wire logic [CHANNEL_BITS-1:0]      out_opacity,
  input wire logic                         out_last_pixel
);

  // A stalled pixel stays offered and unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_x) && $stable(out_pixel_y)
      && $stable(out_red) && $stable(out_green) && $stable(out_blue)
      && $stable(out_opacity) && $stable(out_last_pixel))
    else $error("stalled pixel changed or dropped");

  // Segment setup keeps the input side closed in the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == mlcr_pkg::OP_LOAD |=> !in_ready)
    else $error("input accepted during segment setup");

  // A new pixel only appears at the end of a busy sequence, never straight from idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("pixel emitted without a busy sequence");

  // A load item produces no pixel.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == mlcr_pkg::OP_LOAD && !out_valid |=> !out_valid)
    else $error("load item produced a pixel");

endmodule

bind midpoint_line_color_raster mlcr_checker #(
  .COORD_BITS   (COORD_BITS),
  .CHANNEL_BITS (CHANNEL_BITS)
) u_mlcr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_operation   (in_ch.operation),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_pixel_x    (out_ch.pixel_x),
  .out_pixel_y    (out_ch.pixel_y),
  .out_red        (out_ch.red),
  .out_green      (out_ch.green),
  .out_blue       (out_ch.blue),
  .out_opacity    (out_ch.opacity),
  .out_last_pixel (out_ch.last_pixel)
);

`default_nettype wire

/* sim/tb_midpoint_line_color_raster.sv */
// Self-checking regression for the midpoint line rasterizer with per-pixel color blending.
module tb_midpoint_line_color_raster;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW          = mlcr_pkg::COORD_BITS_DEF;
  localparam int CHW         = mlcr_pkg::CHANNEL_BITS_DEF;
  localparam int COORD_MAX   = 2 ** (CW - 1) - 1;
  localparam int COORD_MIN   = -(2 ** (CW - 1));
  localparam int PERIOD      = 4;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_END  = 620;
  localparam int QUIET_FROM  = 540;
  localparam int DRAIN_WAIT  = 150;

  typedef struct {
    logic                    op;
    logic signed [CW-1:0]    xs;
    logic signed [CW-1:0]    ys;
    logic signed [CW-1:0]    xe;
    logic signed [CW-1:0]    ye;
    logic [4*CHW-1:0]        cs;
    logic [4*CHW-1:0]        ce;
  } seg_item_t;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [CHW-1:0]       red;
    logic [CHW-1:0]       green;
    logic [CHW-1:0]       blue;
    logic [CHW-1:0]       opacity;
    logic                 last_pixel;
  } pixel_t;

  // Walks each loaded segment the way the block should and keeps the pixels still owed.
  class line_pixel_board;
    pixel_t     pending_pixels[$];
    int         mismatches;
    bit         active, steep, down;
    int         maj, mnr, maj_stop, decision, steps, span, mspan;
    logic [4*CHW-1:0] col_a, col_b;

    function int mag(int v);
      return (v < 0) ? -v : v;
    endfunction

    // Channel index 0 is red, in the top bits of the packed color.
    function logic [CHW-1:0] blend(int chan);
      int sh, a, b;
      sh = (mlcr_pkg::NUM_CHANNELS - 1 - chan) * CHW;
      a  = int'((col_a >> sh) & ((1 << CHW) - 1));
      b  = int'((col_b >> sh) & ((1 << CHW) - 1));
      return CHW'((a * (span - steps) + b * steps) / span);
    endfunction

    function void take_segment_item(seg_item_t it);
      int xa, ya, xb, yb, ma, na, mb, nb, t;
      logic [4*CHW-1:0] ca, cb, tc;
      pixel_t px;
      if (it.op == mlcr_pkg::OP_LOAD) begin
        xa = it.xs;
        ya = it.ys;
        xb = it.xe;
        yb = it.ye;
        ca = it.cs;
        cb = it.ce;
        steep = mag(yb - ya) > mag(xb - xa);
        if (steep) begin
          ma = ya; na = xa; mb = yb; nb = xb;
        end else begin
          ma = xa; na = ya; mb = xb; nb = yb;
        end
        if (ma > mb) begin
          t = ma; ma = mb; mb = t;
          t = na; na = nb; nb = t;
          tc = ca; ca = cb; cb = tc;
        end
        maj      = ma;
        mnr      = na;
        maj_stop = mb;
        down     = nb < na;
        span     = mb - ma;
        mspan    = mag(nb - na);
        decision = 2 * mspan - span;
        steps    = 0;
        col_a    = ca;
        col_b    = cb;
        active   = span != 0;
      end else if (active) begin
        px.x          = CW'(steep ? mnr : maj);
        px.y          = CW'(steep ? maj : mnr);
        px.red        = blend(0);
        px.green      = blend(1);
        px.blue       = blend(2);
        px.opacity    = blend(3);
        px.last_pixel = (steps + 1 == span);
        pending_pixels.push_back(px);
        if (decision <= 0) begin
          decision += 2 * mspan;
        end else begin
          decision += 2 * (mspan - span);
          mnr += down ? -1 : 1;
        end
        maj++;
        steps++;
        if (steps >= span || maj >= maj_stop) active = 0;
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      string  names[7];
      int     wv[7], gv[7];
      if (pending_pixels.size() == 0) begin
        $error("pixel at x %0d y %0d arrived with none expected", got.x, got.y);
        mismatches++;
        return;
      end
      want  = pending_pixels.pop_front();
      names = '{"pixel_x", "pixel_y", "red", "green", "blue", "opacity", "last_pixel"};
      wv = '{want.x, want.y, want.red, want.green, want.blue, want.opacity, want.last_pixel};
      gv = '{got.x, got.y, got.red, got.green, got.blue, got.opacity, got.last_pixel};
      for (int i = 0; i < 7; i++) begin
        if (wv[i] != gv[i]) begin
          $error("%s: expected %0d, got %0d", names[i], wv[i], gv[i]);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   cycles = 0;
  int   items_sent = 0;
  bit   quiet = 0;
  line_pixel_board sb;

  mlcr_in_if  in_ch();
  mlcr_out_if out_ch();

  midpoint_line_color_raster dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("midpoint_line_color_raster regression: fail");
      $finish;
    end
  end

  // Idling comes in windows so that some long stretches run at full rate.
  function bit idling_allowed();
    return !quiet && ((cycles >> 9) % 3 != 2);
  endfunction

  function int far_end(int s, int d);
    int e;
    e = s + d;
    if (e > COORD_MAX || e < COORD_MIN) e = s - d;
    return e;
  endfunction

  function seg_item_t load_item(int xs, int ys, int xe, int ye,
                                logic [4*CHW-1:0] cs, logic [4*CHW-1:0] ce);
    seg_item_t it;
    it.op = mlcr_pkg::OP_LOAD;
    it.xs = CW'(xs);
    it.ys = CW'(ys);
    it.xe = CW'(xe);
    it.ye = CW'(ye);
    it.cs = cs;
    it.ce = ce;
    return it;
  endfunction

  // Step items carry random coordinates and colors that the block must ignore.
  function seg_item_t step_item();
    seg_item_t it;
    it    = load_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    it.op = mlcr_pkg::OP_STEP;
    return it;
  endfunction

  task automatic send(input seg_item_t it);
    if (idling_allowed() && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= it.op;
    in_ch.x_start     <= it.xs;
    in_ch.y_start     <= it.ys;
    in_ch.x_end       <= it.xe;
    in_ch.y_end       <= it.ye;
    in_ch.color_start <= it.cs;
    in_ch.color_end   <= it.ce;
    do @(posedge clk); while (!in_ch.ready);
    sb.take_segment_item(it);
    items_sent++;
  endtask

  // Result side: checks every accepted pixel and stalls in bursts, with one long hold-off.
  int  pixels_seen = 0;
  int  rx_stall = 0;
  bit  long_hold_done = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        sb.check_pixel('{out_ch.pixel_x, out_ch.pixel_y, out_ch.red, out_ch.green,
                         out_ch.blue, out_ch.opacity, out_ch.last_pixel});
        pixels_seen++;
      end
      if (!long_hold_done && pixels_seen >= 40) begin
        long_hold_done = 1;
        rx_stall = 400;
      end else if (rx_stall == 0 && idling_allowed() && $urandom_range(0, 7) == 0) begin
        rx_stall = $urandom_range(1, 16);
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end else begin
      out_ch.ready <= 1'b0;
    end
  end

  initial begin
    int xs, ys, dx, dy, lim, n, r;
    sb = new();
    rst_n = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.operation   = mlcr_pkg::OP_STEP;
    in_ch.x_start     = '0;
    in_ch.y_start     = '0;
    in_ch.x_end       = '0;
    in_ch.y_end       = '0;
    in_ch.color_start = '0;
    in_ch.color_end   = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: idle step, zero length, steep reversed, diagonal, longest spans.
    send(step_item());
    send(load_item(5, 5, 5, 5, 32'hFFFF_FFFF, 32'h0000_0000));
    send(step_item());
    send(load_item(COORD_MAX, COORD_MAX, COORD_MAX - 1, COORD_MAX - 4,
                   32'hFF00_FF00, 32'h00FF_00FF));
    repeat (5) send(step_item());
    send(load_item(COORD_MIN, COORD_MAX, COORD_MIN + 3, COORD_MAX - 3,
                   32'h0000_0000, 32'hFFFF_FFFF));
    repeat (3) send(step_item());
    send(load_item(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                   32'hFFFF_FFFF, 32'h0000_0000));
    repeat (2) send(step_item());
    send(load_item(COORD_MIN, COORD_MIN, COORD_MIN + 1, COORD_MAX,
                   32'h8040_2010, 32'h0102_0408));
    send(step_item());
    send(load_item(COORD_MAX, COORD_MIN, COORD_MAX - 3, COORD_MIN,
                   32'h1234_5678, 32'hFEDC_BA98));
    repeat (3) send(step_item());
    send(load_item(0, 0, 1, 0, 32'hA5A5_5A5A, 32'h5A5A_A5A5));
    send(step_item());

    // Random part: mostly a load followed by about as many steps as the segment has pixels.
    while (items_sent < RANDOM_END) begin
      if (items_sent >= QUIET_FROM) quiet = 1;
      r = $urandom_range(0, 99);
      if (r < 80) begin
        lim = ($urandom_range(0, 9) == 0) ? 200 : 24;
        dx  = int'($urandom_range(0, 2 * lim)) - lim;
        dy  = int'($urandom_range(0, 2 * lim)) - lim;
        if ($urandom_range(0, 9) == 0) dy = $urandom_range(0, 1) ? dx : -dx;
        xs  = int'($urandom_range(0, 2 ** CW - 1)) + COORD_MIN;
        ys  = int'($urandom_range(0, 2 ** CW - 1)) + COORD_MIN;
        dx  = far_end(xs, dx);
        dy  = far_end(ys, dy);
        send(load_item(xs, ys, dx, dy, $urandom, $urandom));
        dx = (dx > xs) ? dx - xs : xs - dx;
        dy = (dy > ys) ? dy - ys : ys - dy;
        n  = (dx > dy) ? dx : dy;
        case ($urandom_range(0, 5))
          0: n = $urandom_range(0, n);
          1: n += $urandom_range(1, 3);
          default: ;
        endcase
        if (n > 40) n = 40;
        repeat (n) send(step_item());
      end else if (r < 90) begin
        repeat ($urandom_range(1, 3)) send(step_item());
      end else begin
        send(load_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
        repeat ($urandom_range(0, 6)) send(step_item());
      end
    end

    in_ch.valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_pixels.size() == 0) begin
      $display("midpoint_line_color_raster regression: pass");
    end else begin
      $display("midpoint_line_color_raster regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/mlcr_pkg.sv
rtl/mlcr_if.sv
rtl/mlcr_div.sv
rtl/mlcr_walk.sv
rtl/midpoint_line_color_raster.sv
rtl/mlcr_checker.sv
sim/tb_midpoint_line_color_raster.sv
